// File: src/positional_list_insert_erase_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the positional list insert/erase unit
// Each check can be compiled out by defining NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_ERASE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_INSERT_ERASE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, clocked on clk, off during reset
`define PLIE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plie check failed");

// next-cycle implication
`define PLIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plie check failed");

`else

`define PLIE_ASSERT_IMPL(label, ante, cons)
`define PLIE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: src/plie_pkg.sv
// ---------------------------------------------------------------------------
// plie_pkg
// Shared constants and codes of the positional list insert/erase unit.
// ---------------------------------------------------------------------------
package plie_pkg;

  localparam int DEF_CAPACITY   = 256;
  localparam int DEF_WORD_WIDTH = 32;

  localparam int REQ_W       = 2;
  localparam int POS_W       = 8;
  localparam int VALUE_W     = 32;
  localparam int OUT_WORD_W  = 32;
  localparam int OUT_COUNT_W = 9;
  localparam int STATUS_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_WRITE  = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_FIN   = 6'b001000,
    S_PUT   = 6'b010000,
    S_RESP  = 6'b100000
  } plie_state_t;

endpackage

// File: src/plie_mem.sv
// ---------------------------------------------------------------------------
// plie_mem
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module plie_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/positional_list_insert_erase_unit.sv
// ---------------------------------------------------------------------------
// positional_list_insert_erase_unit
// Fixed-capacity ordered list of words with insert, erase, read and write.
// ---------------------------------------------------------------------------
// One request is handled at a time; in_ready is high only while the unit is
// idle. Entries live in a single memory with one write and one registered
// read port, so an insert or erase moves the later entries one per cycle.
// An insert that moves entries passes through S_EVAL, S_SHIFT, S_FIN, S_PUT
// and S_RESP, an erase that moves entries through S_EVAL, S_SHIFT, S_FIN and
// S_RESP, and read, write, rejected requests or moves of nothing through
// S_EVAL and S_RESP. in_ready rises together with out_valid, so the longest
// gap from one accept to the next comes with an insert at position 0 into
// CAPACITY - 1 entries. No clearing pass follows reset. A finished
// result waits in the output register; the next word is accepted meanwhile.
module positional_list_insert_erase_unit
  import plie_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [REQ_W-1:0]       in_req_type,
  input  logic [POS_W-1:0]       in_position,
  input  logic [VALUE_W-1:0]     in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_WORD_W-1:0]  out_read_word,
  output logic [OUT_COUNT_W-1:0] out_item_count,
  output logic [STATUS_W-1:0]    out_status
);

`include "positional_list_insert_erase_unit_macros.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  plie_state_t state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [AW-1:0]          pend_addr_r, pend_addr_nxt;
  logic                   pend_r;
  status_t                status_r, status_nxt;
  req_type_t              kind_r;
  logic [POS_W-1:0]       pos_r;
  logic [WORD_WIDTH-1:0]  val_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_WORD_W-1:0]  word_r, word_nxt;
  logic [OUT_COUNT_W-1:0] ocnt_r, ocnt_nxt;
  logic [STATUS_W-1:0]    ostat_r, ostat_nxt;

  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [WORD_WIDTH-1:0]  mem_wdata, mem_rdata;

  logic [PW-1:0]          pos_x, cnt_x;
  logic [AW-1:0]          pos_a, last_a;
  logic                   in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign pos_x    = PW'(pos_r);
  assign cnt_x    = PW'(cnt_r);
  assign pos_a    = AW'(pos_r);
  assign last_a   = AW'(cnt_r - CW'(1));

  plie_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pend_addr_nxt = pend_addr_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    word_nxt      = word_r;
    ocnt_nxt      = ocnt_r;
    ostat_nxt     = ostat_r;
    mem_we        = 1'b0;
    mem_waddr     = pend_addr_r;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;

    unique case (state_r)
      S_IDLE: begin
        status_nxt = ST_DONE;
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_RESP;
        if (kind_r == REQ_INSERT) begin
          if (pos_x > cnt_x) begin
            status_nxt = ST_RANGE;
          end else if (cnt_r == CW'(CAPACITY)) begin
            status_nxt = ST_FULL;
          end else if (pos_x == cnt_x) begin
            // append: nothing to move
            mem_we    = 1'b1;
            mem_waddr = pos_a;
            mem_wdata = val_r;
            cnt_nxt   = cnt_r + CW'(1);
          end else begin
            idx_nxt   = last_a;
            state_nxt = S_SHIFT;
          end
        end else if (pos_x >= cnt_x) begin
          status_nxt = ST_RANGE;
        end else begin
          case (kind_r)
            REQ_ERASE: begin
              if (pos_x + PW'(1) == cnt_x) begin
                cnt_nxt = cnt_r - CW'(1);
              end else begin
                idx_nxt   = pos_a + AW'(1);
                state_nxt = S_SHIFT;
              end
            end
            REQ_READ: begin
              mem_re    = 1'b1;
              mem_raddr = pos_a;
            end
            default: begin
              mem_we    = 1'b1;
              mem_waddr = pos_a;
              mem_wdata = val_r;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // read one entry per cycle; the word read last cycle lands now
        mem_re = 1'b1;
        mem_we = pend_r;
        if (kind_r == REQ_INSERT) begin
          pend_addr_nxt = idx_r + AW'(1);
          idx_nxt       = idx_r - AW'(1);
          if (idx_r == pos_a) begin
            state_nxt = S_FIN;
          end
        end else begin
          pend_addr_nxt = idx_r - AW'(1);
          idx_nxt       = idx_r + AW'(1);
          if (idx_r == last_a) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        mem_we = 1'b1;
        if (kind_r == REQ_INSERT) begin
          state_nxt = S_PUT;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_RESP;
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_a;
        mem_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          word_nxt      = (kind_r == REQ_READ && status_r == ST_DONE) ?
                          OUT_WORD_W'(mem_rdata) : '0;
          ocnt_nxt      = OUT_COUNT_W'(cnt_r);
          ostat_nxt     = status_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= (state_r == S_SHIFT);
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    word_r      <= word_nxt;
    ocnt_r      <= ocnt_nxt;
    ostat_r     <= ostat_nxt;
    if (in_acc) begin
      kind_r <= req_type_t'(in_req_type);
      pos_r  <= in_position;
      val_r  <= WORD_WIDTH'(in_value);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_word  = word_r;
  assign out_item_count = ocnt_r;
  assign out_status     = ostat_r;

  `PLIE_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_r <= CW'(CAPACITY))
  `PLIE_ASSERT_NEXT(a_acc_eval, in_acc, state_r == S_EVAL)
  `PLIE_ASSERT_NEXT(a_cnt_hold, state_r == S_SHIFT || state_r == S_IDLE, $stable(cnt_r))
  `PLIE_ASSERT_IMPL(a_fin_pend, state_r == S_FIN, pend_r)

endmodule

// File: verif/positional_list_insert_erase_unit_tb.sv
// ---------------------------------------------------------------------------
// positional_list_insert_erase_unit_tb
// Self-checking bench for the positional list unit. A local list model
// predicts every result (read word, entry count, status) as each request is
// accepted. Directed requests hit the empty list and both ends. Random
// traffic fills the list to capacity and drains it, then mixes all request
// kinds. Both sides stall at random except in the final back-to-back part.
// ---------------------------------------------------------------------------
module positional_list_insert_erase_unit_tb;
  import plie_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP    = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYC  = LIST_CAP + 40;

  typedef struct packed {
    logic [OUT_WORD_W-1:0]  read_word;
    logic [OUT_COUNT_W-1:0] item_count;
    status_t                status;
  } list_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [REQ_W-1:0]       in_req_type;
  logic [POS_W-1:0]       in_position;
  logic [VALUE_W-1:0]     in_value;
  logic                   out_valid;
  logic                   out_ready;
  logic [OUT_WORD_W-1:0]  out_read_word;
  logic [OUT_COUNT_W-1:0] out_item_count;
  logic [STATUS_W-1:0]    out_status;

  // list model
  logic [VALUE_W-1:0] list_words [LIST_CAP];
  int                 list_len;
  int                 peak_len;

  list_result_t pending_results [$];
  bit           idle_on;
  int           cycle_count;
  int           err_count;
  int           words_sent;
  int           results_checked;
  int           range_seen;
  int           full_seen;

  positional_list_insert_erase_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_word  (out_read_word),
    .out_item_count (out_item_count),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Applies one request to the list model and returns what the unit owes.
  function automatic list_result_t apply_list_request(req_type_t kind,
                                                      logic [POS_W-1:0] pos,
                                                      logic [VALUE_W-1:0] val);
    list_result_t res;
    int           p;
    p = int'(pos);
    res.read_word = '0;
    res.status    = ST_DONE;
    if (kind == REQ_INSERT) begin
      // range check wins over full
      if (p > list_len) begin
        res.status = ST_RANGE;
      end else if (list_len >= LIST_CAP) begin
        res.status = ST_FULL;
      end else begin
        for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
        list_words[p] = val;
        list_len++;
      end
    end else if (p >= list_len) begin
      res.status = ST_RANGE;
    end else if (kind == REQ_ERASE) begin
      for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
      list_len--;
    end else if (kind == REQ_READ) begin
      res.read_word = list_words[p];
    end else begin
      list_words[p] = val;
    end
    if (list_len > peak_len) peak_len = list_len;
    res.item_count = OUT_COUNT_W'(list_len);
    return res;
  endfunction

  function automatic logic [POS_W-1:0] pick_position(bit for_insert);
    int top;
    top = for_insert ? list_len : list_len - 1;
    if (top > 255) top = 255;
    if (top < 0) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(0, top));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // Sends one word and records its expected result at the accepting edge.
  task automatic send_word(req_type_t kind, logic [POS_W-1:0] pos,
                           logic [VALUE_W-1:0] val);
    list_result_t exp_res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    @(negedge clk);
    in_valid    = 1'b1;
    in_req_type = kind;
    in_position = pos;
    in_value    = val;
    do @(posedge clk); while (!in_ready);
    exp_res = apply_list_request(kind, pos, val);
    pending_results = {pending_results, exp_res};
    words_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    list_result_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no request outstanding");
        err_count++;
      end else begin
        exp = pending_results.pop_front();
        results_checked++;
        if (out_read_word !== exp.read_word) begin
          $error("read_word: expected %08h, got %08h", exp.read_word, out_read_word);
          err_count++;
        end
        if (out_item_count !== exp.item_count) begin
          $error("item_count: expected %0d, got %0d", exp.item_count, out_item_count);
          err_count++;
        end
        if (out_status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, out_status);
          err_count++;
        end
        if (exp.status == ST_RANGE) range_seen++;
        if (exp.status == ST_FULL) full_seen++;
      end
    end
  end

  // result-side backpressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  task automatic test_empty_list();
    send_word(REQ_ERASE, 8'd0, 32'h0000_0000);
    send_word(REQ_READ, 8'd0, 32'hFFFF_FFFF);
    send_word(REQ_WRITE, 8'd255, 32'hFFFF_FFFF);
    send_word(REQ_READ, 8'd255, 32'h0000_0000);
    send_word(REQ_INSERT, 8'd1, 32'h1234_5678);
    send_word(REQ_INSERT, 8'd255, 32'hFFFF_FFFF);
  endtask

  task automatic test_push_ends();
    send_word(REQ_INSERT, 8'd0, 32'h0000_0000);
    send_word(REQ_INSERT, POS_W'(list_len), 32'hFFFF_FFFF);  // push-back
    send_word(REQ_INSERT, 8'd0, 32'hA5A5_A5A5);              // push-front
    send_word(REQ_INSERT, 8'd1, 32'h5A5A_5A5A);
    for (int i = 0; i < 4; i++) send_word(REQ_READ, POS_W'(i), 32'hFFFF_FFFF);
    send_word(REQ_WRITE, 8'd3, 32'h0000_0000);
    send_word(REQ_READ, 8'd3, 32'h0000_0000);
    send_word(REQ_READ, 8'd4, 32'h0000_0000);
    send_word(REQ_ERASE, 8'd4, 32'h0000_0000);
    send_word(REQ_WRITE, 8'd4, 32'hDEAD_BEEF);
    send_word(REQ_ERASE, 8'd3, 32'h0000_0000);   // last entry
    send_word(REQ_ERASE, 8'd0, 32'h0000_0000);   // first entry
    send_word(REQ_ERASE, 8'd0, 32'h0000_0000);
    send_word(REQ_READ, 8'd0, 32'h0000_0000);
    send_word(REQ_ERASE, 8'd0, 32'h0000_0000);
  endtask

  // Grow to capacity with mostly inserts, poke the full list, then drain.
  task automatic test_fill_and_drain();
    int roll;
    while (list_len < LIST_CAP) begin
      roll = $urandom_range(0, 19);
      if (roll < 17)
        send_word(REQ_INSERT, pick_position(1'b1), pick_value());
      else if (roll == 17)
        send_word(REQ_READ, pick_position(1'b0), pick_value());
      else if (roll == 18)
        send_word(REQ_WRITE, pick_position(1'b0), pick_value());
      else
        send_word(req_type_t'($urandom_range(0, 3)), POS_W'($urandom_range(0, 255)),
                  $urandom);
    end
    repeat (6) send_word(REQ_INSERT, pick_position(1'b1), pick_value());
    send_word(REQ_WRITE, 8'd255, pick_value());
    send_word(REQ_READ, 8'd255, pick_value());
    send_word(REQ_READ, 8'd0, pick_value());
    while (list_len > 0) begin
      roll = $urandom_range(0, 19);
      if (roll < 17)
        send_word(REQ_ERASE, pick_position(1'b0), pick_value());
      else if (roll == 17)
        send_word(REQ_READ, pick_position(1'b0), pick_value());
      else if (roll == 18)
        send_word(REQ_WRITE, pick_position(1'b0), pick_value());
      else
        send_word(req_type_t'($urandom_range(0, 3)), POS_W'($urandom_range(0, 255)),
                  $urandom);
    end
  endtask

  task automatic test_random_mix(int n_words);
    req_type_t kind;
    for (int k = 0; k < n_words; k++) begin
      kind = req_type_t'($urandom_range(0, 3));
      if ($urandom_range(0, 4) != 0)
        send_word(kind, pick_position(kind == REQ_INSERT), pick_value());
      else
        send_word(kind, POS_W'($urandom_range(0, 255)), $urandom);
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_mix(200);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_INSERT;
    in_position = '0;
    in_value    = '0;
    idle_on     = 1'b1;
    list_len    = 0;
    peak_len    = 0;
    err_count   = 0;
    words_sent  = 0;
    results_checked = 0;
    range_seen  = 0;
    full_seen   = 0;
    foreach (list_words[i]) list_words[i] = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_push_ends();
    wait_for_results();
    test_fill_and_drain();
    test_random_mix(550);
    test_back_to_back();

    wait_for_results();
    repeat (SETTLE_CYC) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      err_count++;
    end
    $display("%0d requests sent, %0d results checked, %0d range and %0d full refusals",
             words_sent, results_checked, range_seen, full_seen);
    $display("list filled to %0d of %0d entries and emptied again; %0d errors",
             peak_len, LIST_CAP, err_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
